// ===== hw/rtl/haptic_pulse_ramp_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef HAPTIC_PULSE_RAMP_SEQUENCER_DEFINES_SVH
`define HAPTIC_PULSE_RAMP_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define HPRS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hprs assertion failed");

// next-cycle implication
`define HPRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hprs assertion failed");

`endif

// ===== hw/rtl/hprs_pkg.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer package
// Beat types, codes and elaboration-time helpers for the interval table.
// ----------------------------------------------------------------------------
package hprs_pkg;

   localparam int START_INTERVAL_MS_DEF = 1000;
   localparam int END_INTERVAL_MS_DEF   = 50;
   localparam int MAX_STEPS_DEF         = 40;

   localparam int IV_W    = 14;     // table entry width, covers intervals up to 16000
   localparam int WAIT_W  = 15;
   localparam int STEP_W  = 6;
   localparam int MIN_W   = 10;
   localparam int WAIT_MAX = 32767;
   localparam int BIG_W   = 1024;   // exact power arithmetic at elaboration

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // length rows of the interval table
   localparam logic [1:0] LEN_SHORT = 2'd0;
   localparam logic [1:0] LEN_MED   = 2'd1;
   localparam logic [1:0] LEN_LONG  = 2'd2;

   localparam logic [7:0] EFFECT_A = 8'd17;
   localparam logic [7:0] EFFECT_B = 8'd24;
   localparam logic [7:0] EFFECT_C = 8'd4;
   localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 10'd10;
   localparam logic [STEP_W-1:0] STEP_TOTAL_RST  = 6'd10;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_UP     = 3'd1,
      PH_PAUSE1 = 3'd2,
      PH_DOWN   = 3'd3,
      PH_PAUSE2 = 3'd4
   } hprs_phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] haptic_type;
      logic [7:0] length_code;
   } hprs_req_type;

   typedef struct packed {
      logic       fire;
      logic [7:0] effect_id;
      logic [2:0] phase;
      logic       stopped;
      logic       done_res;
   } hprs_rsp_type;

   // step count of a length row, saturated at the step limit
   function automatic int row_steps(int row, int max_steps);
      int base;
      base = (row == 1) ? 20 : ((row == 2) ? 40 : 10);
      return (base > max_steps) ? max_steps : base;
   endfunction

   // pause length of a row: steps * start / 2, saturated
   function automatic int pause_ms(int steps, int start_ms);
      int t;
      t = (steps * start_ms) >> 1;
      return (t > WAIT_MAX) ? WAIT_MAX : t;
   endfunction

   // largest v with v^k <= s^(k-i) * e^i
   function automatic int interval_at(int s, int e, int k, int i);
      logic [BIG_W-1:0] p;
      logic [BIG_W-1:0] q;
      int lo;
      int hi;
      int mid;
      int j;
      if (i > k || k < 1) begin
         return 0;
      end
      p = BIG_W'(1);
      for (j = 0; j < k - i; j++) p = p * BIG_W'(s);
      for (j = 0; j < i; j++) p = p * BIG_W'(e);
      lo = 0;
      hi = (s > e) ? s : e;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         q = BIG_W'(1);
         for (j = 0; j < k; j++) q = q * BIG_W'(mid);
         if (q <= p) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

endpackage

// ===== hw/rtl/haptic_pulse_ramp_sequencer.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer
// Start / tick / stop driven trigger sequencer with geometric ramps.
// ----------------------------------------------------------------------------
//
//   channel  | ports             | beat
//   ---------+-------------------+-------------------------------------------
//   request  | req_valid/ready   | opcode, haptic_type, length_code
//   response | rsp_valid/ready   | fire, effect_id, phase, stopped, done_res
//   csr      | csr_wr_en/wr_data | min_interval_ms, write-only, no wait
//
// One request beat yields one response beat, passing through a request
// register, then the state update and the interval table lookup, done
// combinationally into the response register.
// Sustained rate is one beat per cycle; the pipeline stalls only when the
// response register is full and not taken.
// Reset (synchronous) empties both registers and restores the idle state,
// effect 17, ten steps and a clamp of 10 ms.
// ----------------------------------------------------------------------------
module haptic_pulse_ramp_sequencer #(
   parameter int START_INTERVAL_MS = hprs_pkg::START_INTERVAL_MS_DEF,
   parameter int END_INTERVAL_MS   = hprs_pkg::END_INTERVAL_MS_DEF,
   parameter int MAX_STEPS         = hprs_pkg::MAX_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  hprs_pkg::hprs_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output hprs_pkg::hprs_rsp_type     rsp_data,
   input  logic                       csr_wr_en,
   input  logic [hprs_pkg::MIN_W-1:0] csr_wr_data
);

   // request stage
   logic                   in_valid_ff, in_valid_in;
   hprs_pkg::hprs_req_type in_data_ff;

   // response stage
   logic                   rsp_valid_ff, rsp_valid_in;
   hprs_pkg::hprs_rsp_type rsp_data_ff;

   hprs_pkg::hprs_rsp_type core_result;
   logic                   advance;
   logic                   req_take;

   // the held beat moves on whenever the response slot is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   // sequence state commits only when the beat advances
   hprs_seq_core #(
      .START_INTERVAL_MS (START_INTERVAL_MS),
      .END_INTERVAL_MS   (END_INTERVAL_MS),
      .MAX_STEPS         (MAX_STEPS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .item_go     (advance),
      .item        (in_data_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/hprs_interval_rom.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer interval table
// Constant geometric ramp intervals, one row per length choice.
// ----------------------------------------------------------------------------
module hprs_interval_rom #(
   parameter int START_INTERVAL_MS = hprs_pkg::START_INTERVAL_MS_DEF,
   parameter int END_INTERVAL_MS   = hprs_pkg::END_INTERVAL_MS_DEF,
   parameter int MAX_STEPS         = hprs_pkg::MAX_STEPS_DEF,
   parameter int IDX_W             = $clog2(MAX_STEPS)
) (
   input  logic [1:0]                row_sel,
   input  logic [IDX_W-1:0]          idx,
   output logic [hprs_pkg::IV_W-1:0] value
);

   logic [hprs_pkg::IV_W-1:0] tab [3][MAX_STEPS];

   for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int N = hprs_pkg::row_steps(r, MAX_STEPS);
      for (genvar i = 0; i < MAX_STEPS; i++) begin : g_ent
         localparam int V =
            hprs_pkg::interval_at(START_INTERVAL_MS, END_INTERVAL_MS, N - 1, i);
         assign tab[r][i] = hprs_pkg::IV_W'(V);
      end
   end

   always_comb begin
      case (row_sel)
         hprs_pkg::LEN_MED:  value = tab[1][idx];
         hprs_pkg::LEN_LONG: value = tab[2][idx];
         default:            value = tab[0][idx];
      endcase
   end

endmodule

// ===== hw/rtl/hprs_seq_core.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer core
// Sequence state and its one-beat update, plus the clamp register.
// ----------------------------------------------------------------------------
module hprs_seq_core #(
   parameter int START_INTERVAL_MS = hprs_pkg::START_INTERVAL_MS_DEF,
   parameter int END_INTERVAL_MS   = hprs_pkg::END_INTERVAL_MS_DEF,
   parameter int MAX_STEPS         = hprs_pkg::MAX_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_go,
   input  hprs_pkg::hprs_req_type     item,
   input  logic                       csr_wr_en,
   input  logic [hprs_pkg::MIN_W-1:0] csr_wr_data,
   output hprs_pkg::hprs_rsp_type     result
);

   localparam int IDX_W   = $clog2(MAX_STEPS);
   localparam int N_SHORT = hprs_pkg::row_steps(0, MAX_STEPS);
   localparam int N_MED   = hprs_pkg::row_steps(1, MAX_STEPS);
   localparam int N_LONG  = hprs_pkg::row_steps(2, MAX_STEPS);
   localparam int P_SHORT = hprs_pkg::pause_ms(N_SHORT, START_INTERVAL_MS);
   localparam int P_MED   = hprs_pkg::pause_ms(N_MED, START_INTERVAL_MS);
   localparam int P_LONG  = hprs_pkg::pause_ms(N_LONG, START_INTERVAL_MS);

   hprs_pkg::hprs_phase_type         phase_ff, phase_in;
   logic [hprs_pkg::STEP_W-1:0]      step_index_ff, step_index_in;
   logic [hprs_pkg::STEP_W-1:0]      step_total_ff, step_total_in;
   logic [1:0]                       row_ff, row_in;
   logic [hprs_pkg::WAIT_W-1:0]      wait_count_ff, wait_count_in;
   logic [7:0]                       effect_ff, effect_in;
   logic                             stopped_ff, stopped_in;
   logic [hprs_pkg::MIN_W-1:0]       min_ivl_ff;

   logic [1:0]                       new_row;
   logic [hprs_pkg::STEP_W-1:0]      new_total;
   logic [7:0]                       new_effect;
   logic [hprs_pkg::STEP_W-1:0]      k_last;
   logic [hprs_pkg::STEP_W-1:0]      si_inc;
   logic [hprs_pkg::STEP_W-1:0]      lk_idx;
   logic [1:0]                       lk_row;
   logic [hprs_pkg::IV_W-1:0]        rom_value;
   logic [hprs_pkg::WAIT_W-1:0]      ramp_wait;
   logic [hprs_pkg::WAIT_W-1:0]      min_wait;
   logic [hprs_pkg::WAIT_W-1:0]      pause_wait;
   logic                             fire;
   logic                             done;

   always_comb begin
      case (item.length_code)
         8'd2:    new_row = hprs_pkg::LEN_MED;
         8'd3:    new_row = hprs_pkg::LEN_LONG;
         default: new_row = hprs_pkg::LEN_SHORT;
      endcase
      case (item.haptic_type)
         8'd2:    new_effect = hprs_pkg::EFFECT_B;
         8'd3:    new_effect = hprs_pkg::EFFECT_C;
         default: new_effect = hprs_pkg::EFFECT_A;
      endcase
      case (new_row)
         hprs_pkg::LEN_MED:  new_total = hprs_pkg::STEP_W'(N_MED);
         hprs_pkg::LEN_LONG: new_total = hprs_pkg::STEP_W'(N_LONG);
         default:            new_total = hprs_pkg::STEP_W'(N_SHORT);
      endcase
      case (row_ff)
         hprs_pkg::LEN_MED:  pause_wait = hprs_pkg::WAIT_W'(P_MED);
         hprs_pkg::LEN_LONG: pause_wait = hprs_pkg::WAIT_W'(P_LONG);
         default:            pause_wait = hprs_pkg::WAIT_W'(P_SHORT);
      endcase
   end

   // table address: start and the second ramp head come first, else the next step
   assign k_last = step_total_ff - 6'd1;
   assign si_inc = step_index_ff + 6'd1;

   always_comb begin
      lk_row = row_ff;
      if (item.opcode == hprs_pkg::OP_START) begin
         lk_row = new_row;
         lk_idx = '0;
      end else if (phase_ff == hprs_pkg::PH_PAUSE1) begin
         lk_idx = k_last;
      end else if (phase_ff == hprs_pkg::PH_DOWN) begin
         lk_idx = k_last - si_inc;
      end else begin
         lk_idx = si_inc;
      end
   end

   hprs_interval_rom #(
      .START_INTERVAL_MS (START_INTERVAL_MS),
      .END_INTERVAL_MS   (END_INTERVAL_MS),
      .MAX_STEPS         (MAX_STEPS),
      .IDX_W             (IDX_W)
   ) u_rom (
      .row_sel (lk_row),
      .idx     (lk_idx[IDX_W-1:0]),
      .value   (rom_value)
   );

   assign min_wait  = hprs_pkg::WAIT_W'(min_ivl_ff);
   assign ramp_wait = (hprs_pkg::WAIT_W'(rom_value) < min_wait) ?
                      min_wait : hprs_pkg::WAIT_W'(rom_value);

   always_comb begin
      phase_in      = phase_ff;
      step_index_in = step_index_ff;
      step_total_in = step_total_ff;
      row_in        = row_ff;
      wait_count_in = wait_count_ff;
      effect_in     = effect_ff;
      stopped_in    = stopped_ff;
      fire          = 1'b0;
      done          = 1'b0;
      case (item.opcode)
         hprs_pkg::OP_START: begin
            if (phase_ff == hprs_pkg::PH_IDLE) begin
               effect_in     = new_effect;
               step_total_in = new_total;
               row_in        = new_row;
               stopped_in    = 1'b0;
               phase_in      = hprs_pkg::PH_UP;
               step_index_in = '0;
               wait_count_in = ramp_wait;
               fire          = 1'b1;
            end
         end
         hprs_pkg::OP_STOP: begin
            if (phase_ff != hprs_pkg::PH_IDLE) begin
               phase_in      = hprs_pkg::PH_IDLE;
               step_index_in = '0;
               wait_count_in = '0;
               stopped_in    = 1'b1;
            end
         end
         hprs_pkg::OP_TICK: begin
            if (phase_ff != hprs_pkg::PH_IDLE) begin
               if (wait_count_ff > 15'd1) begin
                  wait_count_in = wait_count_ff - 15'd1;
               end else begin
                  wait_count_in = '0;
                  case (phase_ff)
                     hprs_pkg::PH_UP, hprs_pkg::PH_DOWN: begin
                        if (si_inc < step_total_ff) begin
                           step_index_in = si_inc;
                           wait_count_in = ramp_wait;
                           fire          = 1'b1;
                        end else begin
                           phase_in      = (phase_ff == hprs_pkg::PH_UP) ?
                                           hprs_pkg::PH_PAUSE1 : hprs_pkg::PH_PAUSE2;
                           step_index_in = '0;
                           wait_count_in = pause_wait;
                        end
                     end
                     hprs_pkg::PH_PAUSE1: begin
                        phase_in      = hprs_pkg::PH_DOWN;
                        step_index_in = '0;
                        wait_count_in = ramp_wait;
                        fire          = 1'b1;
                     end
                     default: begin
                        phase_in      = hprs_pkg::PH_IDLE;
                        step_index_in = '0;
                        done          = 1'b1;
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

   assign result.fire      = fire;
   assign result.effect_id = effect_in;
   assign result.phase     = phase_in;
   assign result.stopped   = stopped_in;
   assign result.done_res  = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hprs_pkg::PH_IDLE;
         step_index_ff <= '0;
         step_total_ff <= hprs_pkg::STEP_TOTAL_RST;
         row_ff        <= hprs_pkg::LEN_SHORT;
         wait_count_ff <= '0;
         effect_ff     <= hprs_pkg::EFFECT_A;
         stopped_ff    <= 1'b0;
      end else if (item_go) begin
         phase_ff      <= phase_in;
         step_index_ff <= step_index_in;
         step_total_ff <= step_total_in;
         row_ff        <= row_in;
         wait_count_ff <= wait_count_in;
         effect_ff     <= effect_in;
         stopped_ff    <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ivl_ff <= hprs_pkg::MIN_INTERVAL_RST;
      end else if (csr_wr_en) begin
         min_ivl_ff <= csr_wr_data;
      end
   end

endmodule

// ===== hw/rtl/hprs_checker.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer checker
// Port-level properties of response beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "haptic_pulse_ramp_sequencer_defines.svh"

module hprs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input hprs_pkg::hprs_req_type     req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input hprs_pkg::hprs_rsp_type     rsp_data,
   input logic                       csr_wr_en,
   input logic [hprs_pkg::MIN_W-1:0] csr_wr_data
);

   // a completed run ends idle, quiet and not halted
   `HPRS_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_data.done_res, rsp_data.phase == 3'd0 && !rsp_data.fire && !rsp_data.stopped)

   // pulses only come from the ramps
   `HPRS_ASSERT_IMPLY(a_fire_ramp, clock, reset, rsp_valid && rsp_data.fire, rsp_data.phase == 3'd1 || rsp_data.phase == 3'd3)

   // halted flag only seen while idle
   `HPRS_ASSERT_IMPLY(a_stop_idle, clock, reset, rsp_valid && rsp_data.stopped, rsp_data.phase == 3'd0)

   // stalled response beat holds
   `HPRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind haptic_pulse_ramp_sequencer hprs_checker u_hprs_checker (.*);

// ===== tb/haptic_pulse_ramp_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// Haptic pulse ramp sequencer testbench
// Drives start, tick, stop and no-op beats into the sequencer under several
// interval clamps, predicts every response beat from a behavioral copy of the
// sequencer state and compares each response field with the oldest
// prediction. Full ramp runs of each length reach both pauses and the done
// beat; random episodes and cut-short runs cover stops in every phase.
// ----------------------------------------------------------------------------
module haptic_pulse_ramp_sequencer_tb;
   import hprs_pkg::*;

   // block configuration, same as the defaults of the instance
   localparam int START_MS  = START_INTERVAL_MS_DEF;
   localparam int END_MS    = END_INTERVAL_MS_DEF;
   localparam int STEPS_CAP = MAX_STEPS_DEF;

   // request field codes
   localparam logic [1:0] OP_NOP         = 2'd3;   // unused opcode, no operation
   localparam logic [7:0] TYPE_SEL_A     = 8'd1;
   localparam logic [7:0] TYPE_SEL_B     = 8'd2;
   localparam logic [7:0] TYPE_SEL_C     = 8'd3;
   localparam logic [7:0] LEN_CODE_SHORT = 8'd1;
   localparam logic [7:0] LEN_CODE_MED   = 8'd2;
   localparam logic [7:0] LEN_CODE_LONG  = 8'd3;
   localparam int STEPS_SHORT = 10;
   localparam int STEPS_MED   = 20;
   localparam int STEPS_LONG  = 40;

   // run control
   localparam int IDLE_PCT     = 19;       // chance of an idle cycle on each side
   localparam int CALM_FROM    = 20000;    // window with no idling at all
   localparam int CALM_TO      = 40000;
   localparam int HOLD_AT_BEAT = 300;      // response count that starts the long hold
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;        // covers the pipe plus margin
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int CHUNK_BEATS  = 340;      // four random chunks

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   hprs_req_type           req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   hprs_rsp_type           rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [MIN_W-1:0]       csr_wr_data = '0;

   haptic_pulse_ramp_sequencer #(
      .START_INTERVAL_MS(START_MS),
      .END_INTERVAL_MS  (END_MS),
      .MAX_STEPS        (STEPS_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 10 time unit clock, low first
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   hprs_req_type req_pending[$];     // beats waiting for the driver
   hprs_rsp_type predicted[$];       // responses owed by the block, oldest first
   int           cycle_count  = 0;
   int           taken_cnt    = 0;   // request beats accepted (posedge side)
   int           seen_cnt     = 0;   // acceptances already seen by the driver
   int           rsp_beats    = 0;
   int           fail_count   = 0;
   logic         calm;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   // ---------------------------------------------------------------------
   // Sequencer model: private copy of the phase machine and the clamp
   // ---------------------------------------------------------------------
   hprs_phase_type     cur_phase  = PH_IDLE;
   logic [STEP_W-1:0]  cur_step   = '0;
   logic [STEP_W-1:0]  cur_steps  = STEP_TOTAL_RST;
   logic [WAIT_W-1:0]  wait_left  = '0;
   logic [7:0]         cur_effect = EFFECT_A;
   logic               halted     = 1'b0;
   logic [MIN_W-1:0]   clamp_ms   = MIN_INTERVAL_RST;

   // unclamped ramp-up interval per step count and step index
   int unsigned geo_ms [64][64];

   // floor of S * (E/S)^(i/k): largest v with v^k <= S^(k-i) * E^i,
   // found bit by bit from the top of the table width
   function automatic int unsigned geo_root(int unsigned k, int unsigned i);
      logic [1023:0] bound;
      logic [1023:0] trial;
      int unsigned   v;
      int unsigned   cand;
      int            j;
      int            b;
      bound = 1;
      for (j = 0; j < int'(k - i); j++) bound = bound * START_MS;
      for (j = 0; j < int'(i); j++) bound = bound * END_MS;
      v = 0;
      for (b = IV_W - 1; b >= 0; b--) begin
         cand  = v | (32'd1 << b);
         trial = 1;
         for (j = 0; j < int'(k); j++) trial = trial * cand;
         if (trial <= bound) v = cand;
      end
      return v;
   endfunction

   function automatic int unsigned steps_for(logic [7:0] lc);
      int unsigned n;
      n = (lc == LEN_CODE_MED) ? STEPS_MED : ((lc == LEN_CODE_LONG) ? STEPS_LONG : STEPS_SHORT);
      return (n > STEPS_CAP) ? STEPS_CAP : n;
   endfunction

   // clamped wait of ramp step i; ramp down walks the table backwards
   function automatic logic [WAIT_W-1:0] ramp_ms(int unsigned n, bit down, int unsigned i);
      int unsigned k;
      int unsigned v;
      k = n - 1;
      if (i > k) i = k;
      v = down ? geo_ms[n][k - i] : geo_ms[n][i];
      if (v < clamp_ms) v = clamp_ms;
      if (v > WAIT_MAX) v = WAIT_MAX;
      return v[WAIT_W-1:0];
   endfunction

   function automatic logic [WAIT_W-1:0] pause_of(int unsigned n);
      int unsigned t;
      t = (n * START_MS) / 2;
      return (t > WAIT_MAX) ? WAIT_MAX : t[WAIT_W-1:0];
   endfunction

   // ticks from a start beat to the done beat, under the current clamp
   function automatic int unsigned run_ticks(int unsigned n);
      int unsigned i;
      int unsigned w;
      int unsigned p;
      int unsigned total;
      total = 0;
      for (i = 0; i < n; i++) begin
         w = ramp_ms(n, 1'b0, i);
         total += (w == 0) ? 1 : w;
      end
      p = pause_of(n);
      return 2 * total + 2 * ((p == 0) ? 1 : p);
   endfunction

   // one accepted request beat in, the response it must produce out
   function automatic hprs_rsp_type sequencer_step(hprs_req_type beat);
      hprs_rsp_type r;
      logic         fire_now;
      logic         done_now;
      fire_now = 1'b0;
      done_now = 1'b0;
      case (beat.opcode)
         OP_START: begin
            // start while busy leaves everything as it is
            if (cur_phase == PH_IDLE) begin
               cur_effect = (beat.haptic_type == TYPE_SEL_B) ? EFFECT_B :
                            ((beat.haptic_type == TYPE_SEL_C) ? EFFECT_C : EFFECT_A);
               cur_steps  = steps_for(beat.length_code);
               halted     = 1'b0;
               cur_phase  = PH_UP;
               cur_step   = '0;
               wait_left  = ramp_ms(cur_steps, 1'b0, 0);
               fire_now   = 1'b1;
            end
         end
         OP_STOP: begin
            if (cur_phase != PH_IDLE) begin
               cur_phase = PH_IDLE;
               cur_step  = '0;
               wait_left = '0;
               halted    = 1'b1;
            end
         end
         OP_TICK: begin
            if (cur_phase != PH_IDLE) begin
               if (wait_left > 1) begin
                  wait_left = wait_left - 1'b1;
               end else begin
                  // wait expires on this tick, also when already zero
                  wait_left = '0;
                  if (cur_phase == PH_UP || cur_phase == PH_DOWN) begin
                     cur_step = cur_step + 1'b1;
                     if (cur_step < cur_steps) begin
                        wait_left = ramp_ms(cur_steps, cur_phase == PH_DOWN, cur_step);
                        fire_now  = 1'b1;
                     end else begin
                        cur_phase = (cur_phase == PH_UP) ? PH_PAUSE1 : PH_PAUSE2;
                        cur_step  = '0;
                        wait_left = pause_of(cur_steps);
                     end
                  end else if (cur_phase == PH_PAUSE1) begin
                     cur_phase = PH_DOWN;
                     cur_step  = '0;
                     wait_left = ramp_ms(cur_steps, 1'b1, 0);
                     fire_now  = 1'b1;
                  end else begin
                     cur_phase = PH_IDLE;
                     cur_step  = '0;
                     done_now  = 1'b1;
                  end
               end
            end
         end
         default: begin
            // no-op opcode, response shows the unchanged state
         end
      endcase
      r.fire      = fire_now;
      r.effect_id = cur_effect;
      r.phase     = cur_phase;
      r.stopped   = halted;
      r.done_res  = done_now;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offers the next pending beat at the falling edge.
   // Valid only drops after an acceptance, never while a beat is offered.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      if (!reset && (!req_valid || taken_cnt != seen_cnt)) begin
         if (req_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_data  <= req_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      seen_cnt = taken_cnt;
   end

   // ---------------------------------------------------------------------
   // Response receiver: random back-pressure plus one long hold, counted
   // here, while the driver keeps offering so the pipe fills and stalls.
   // ---------------------------------------------------------------------
   int  hold_left = 0;
   bit  hold_used = 1'b0;

   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_used && rsp_beats >= HOLD_AT_BEAT) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor at the rising edge: check the response beat against the
   // oldest prediction, then record the request beat taken on this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      hprs_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats = rsp_beats + 1;
            if (predicted.size() == 0) begin
               $error("response beat with no prediction pending");
               fail_count++;
            end else begin
               want = predicted.pop_front();
               if (rsp_data.fire !== want.fire) begin
                  $error("fire: expected %0d, got %0d", want.fire, rsp_data.fire);
                  fail_count++;
               end
               if (rsp_data.effect_id !== want.effect_id) begin
                  $error("effect_id: expected %0d, got %0d", want.effect_id, rsp_data.effect_id);
                  fail_count++;
               end
               if (rsp_data.phase !== want.phase) begin
                  $error("phase: expected %0d, got %0d", want.phase, rsp_data.phase);
                  fail_count++;
               end
               if (rsp_data.stopped !== want.stopped) begin
                  $error("stopped: expected %0d, got %0d", want.stopped, rsp_data.stopped);
                  fail_count++;
               end
               if (rsp_data.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, rsp_data.done_res);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted.push_back(sequencer_step(req_data));
            taken_cnt = taken_cnt + 1;
         end
      end
   end

   // hard stop on a hung run
   always @(posedge clock) begin : watchdog
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus building blocks
   // ---------------------------------------------------------------------
   task automatic push_item(input logic [1:0] op, input logic [7:0] ht, input logic [7:0] lc);
      hprs_req_type b;
      b.opcode      = op;
      b.haptic_type = ht;
      b.length_code = lc;
      req_pending.push_back(b);
   endtask

   // ticks carry random values in the fields they ignore
   task automatic push_ticks(input int unsigned count);
      repeat (count) push_item(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // start beat followed by enough ticks to reach done, or cut short by a
   // stop at a random point anywhere in the four phases
   task automatic run_sequence(input logic [7:0] ht, input logic [7:0] lc, input bit cut);
      int unsigned span;
      span = run_ticks(steps_for(lc));
      push_item(OP_START, ht, lc);
      if (cut) begin
         push_ticks($urandom_range(0, span - 1));
         push_item(OP_STOP, $urandom_range(0, 255), $urandom_range(0, 255));
         push_ticks(2);
      end else begin
         push_ticks(span + 3);
      end
   endtask

   // wait until every beat is sent and answered, then let the pipe settle
   task automatic wait_drained();
      while (req_pending.size() != 0 || req_valid || predicted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // clamp write, only ever issued with the block idle
   task automatic write_clamp(input logic [MIN_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      clamp_ms     = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly well-formed episodes (start, tick stream) with noise mixed in
   task automatic random_chunk(input int unsigned beats);
      int unsigned sent;
      int unsigned len;
      int unsigned r;
      logic [7:0]  ht;
      logic [7:0]  lc;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 9) == 0) begin
            push_item($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255));
            sent++;
         end
         r  = $urandom_range(0, 3);
         ht = (r == 0) ? TYPE_SEL_A : ((r == 1) ? TYPE_SEL_B :
              ((r == 2) ? TYPE_SEL_C : 8'($urandom_range(0, 255))));
         r  = $urandom_range(0, 3);
         lc = (r == 0) ? LEN_CODE_SHORT : ((r == 1) ? LEN_CODE_MED :
              ((r == 2) ? LEN_CODE_LONG : 8'($urandom_range(0, 255))));
         push_item(OP_START, ht, lc);
         sent++;
         len = $urandom_range(0, 40);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               push_ticks(1);
            end else if (r < 87) begin
               push_item(OP_START, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (r < 94) begin
               push_item(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
               push_item(OP_STOP, $urandom_range(0, 255), $urandom_range(0, 255));
            end
            sent++;
         end
         // most episodes end on a stop, the rest run into the next start
         if ($urandom_range(0, 9) < 7) begin
            push_item(OP_STOP, $urandom_range(0, 255), $urandom_range(0, 255));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned n;
      int          c;
      logic [7:0]  codes [3];

      // interval table for every step count a start can select
      codes[0] = LEN_CODE_SHORT;
      codes[1] = LEN_CODE_MED;
      codes[2] = LEN_CODE_LONG;
      for (c = 0; c < 3; c++) begin
         n = steps_for(codes[c]);
         for (int unsigned i = 0; i < n; i++) geo_ms[n][i] = geo_root(n - 1, i);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats under the reset clamp
      push_item(OP_TICK,  8'h00, 8'h00);            // tick while idle
      push_item(OP_STOP,  8'hFF, 8'hFF);            // stop while idle
      push_item(OP_NOP,   8'hFF, 8'hFF);
      push_item(OP_START, 8'hFF, 8'hFF);            // default effect and length
      push_item(OP_START, TYPE_SEL_B, LEN_CODE_LONG); // start while busy
      push_item(OP_TICK,  8'hFF, 8'h00);
      push_item(OP_NOP,   8'h00, 8'hFF);
      push_item(OP_STOP,  8'h00, 8'h00);            // halt in ramp up
      push_item(OP_TICK,  8'h00, 8'h00);            // stopped flag holds
      push_item(OP_STOP,  8'h00, 8'h00);
      push_item(OP_START, TYPE_SEL_B, LEN_CODE_MED);
      push_item(OP_TICK,  8'hAA, 8'h55);
      push_item(OP_STOP,  8'h55, 8'hAA);
      push_item(OP_START, TYPE_SEL_C, LEN_CODE_LONG);
      push_item(OP_STOP,  8'h00, 8'h00);
      push_item(OP_START, TYPE_SEL_A, LEN_CODE_SHORT);
      push_item(OP_STOP,  8'h00, 8'h00);
      push_item(OP_START, 8'h00, 8'h00);
      push_item(OP_STOP,  8'h00, 8'h00);
      push_item(OP_START, 8'h04, 8'h80);
      push_item(OP_STOP,  8'hFF, 8'hFF);
      wait_drained();

      // complete runs through both pauses to the done beat
      write_clamp('0);
      run_sequence(TYPE_SEL_A, LEN_CODE_LONG, 1'b0);
      wait_drained();
      write_clamp(MIN_W'(1000));
      run_sequence(TYPE_SEL_C, LEN_CODE_SHORT, 1'b0);
      wait_drained();
      write_clamp(MIN_W'(300));
      run_sequence(TYPE_SEL_B, LEN_CODE_MED, 1'b0);
      wait_drained();

      // random chunks, each under its own clamp, each with one short run
      // cut by a stop somewhere in its four phases
      repeat (4) begin
         write_clamp(MIN_W'($urandom_range(0, 1000)));
         random_chunk(CHUNK_BEATS);
         push_item(OP_STOP, $urandom_range(0, 255), $urandom_range(0, 255));
         run_sequence($urandom_range(0, 255),
                      ($urandom_range(0, 1) != 0) ? LEN_CODE_SHORT : 8'($urandom_range(4, 255)),
                      1'b1);
         wait_drained();
      end

      if (fail_count == 0 && predicted.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hprs_pkg.sv
hw/rtl/hprs_interval_rom.sv
hw/rtl/hprs_seq_core.sv
hw/rtl/haptic_pulse_ramp_sequencer.sv
hw/rtl/hprs_checker.sv
tb/haptic_pulse_ramp_sequencer_tb.sv
